### src/hdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdg_pkg
// Shared types and constants of the compass heading pipeline.
// ----------------------------------------------------------------------------
package hdg_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int HEADING_W     = 17;
  localparam int DIFF_W        = 17;
  localparam int ANGLE_FRAC    = 16;
  localparam int PRESCALE_BITS = 24;
  localparam int DW            = DIFF_W + PRESCALE_BITS + 3;
  localparam int ZW            = 26;
  localparam int TABLE_LEN     = 24;
  localparam int HALF_TURN_DEG = 180;
  localparam int RIGHT_ANGLE   = 90;
  localparam int CFG_IDX_W     = 2;

  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(RIGHT_ANGLE * (2 ** ANGLE_FRAC));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 2'd0,
    REG_MAX_X = 2'd1,
    REG_MIN_Y = 2'd2,
    REG_MAX_Y = 2'd3
  } hdg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_x;
    logic signed [SAMPLE_W-1:0] max_x;
    logic signed [SAMPLE_W-1:0] min_y;
    logic signed [SAMPLE_W-1:0] max_y;
  } hdg_cal_t;

  typedef struct packed {
    logic                 zero;
    logic signed [ZW-1:0] z;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } hdg_vec_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = ZW'(2949120);
      1:       val = ZW'(1740967);
      2:       val = ZW'(919879);
      3:       val = ZW'(466945);
      4:       val = ZW'(234379);
      5:       val = ZW'(117304);
      6:       val = ZW'(58666);
      7:       val = ZW'(29335);
      8:       val = ZW'(14668);
      9:       val = ZW'(7334);
      10:      val = ZW'(3667);
      11:      val = ZW'(1833);
      12:      val = ZW'(917);
      13:      val = ZW'(458);
      14:      val = ZW'(229);
      15:      val = ZW'(115);
      16:      val = ZW'(57);
      17:      val = ZW'(29);
      18:      val = ZW'(14);
      19:      val = ZW'(7);
      20:      val = ZW'(4);
      21:      val = ZW'(2);
      22:      val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### src/hdg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdg_in_if / hdg_out_if
// Valid/ready channels for sample words and heading words.
// ----------------------------------------------------------------------------
interface hdg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hdg_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [hdg_pkg::SAMPLE_W-1:0] sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface hdg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hdg_pkg::HEADING_W-1:0] heading_deg;

  modport source (output valid, output heading_deg, input ready);
  modport sink   (input valid, input heading_deg, output ready);
endinterface

### src/hdg_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdg_prep
// Removes the hard-iron center and pre-rotates the vector into the right
// half-plane, then scales it up for the rotation cells.
// ----------------------------------------------------------------------------
module hdg_prep (
  input  logic               clk,
  input  logic               rst,
  input  hdg_pkg::hdg_cal_t  cal,
  hdg_in_if.sink             in_word,
  output logic               valid_o,
  input  logic               ready_i,
  output hdg_pkg::hdg_vec_t  vec_o
);

  localparam int DW = hdg_pkg::DW;
  localparam int FW = hdg_pkg::DIFF_W;

  logic signed [FW-1:0] sum_x, sum_y, half_x, half_y, cen_x, cen_y, dx, dy;
  logic signed [DW-1:0] dxw, dyw, xw, yw;
  hdg_pkg::hdg_vec_t    vec_next;
  logic                 valid;

  always_comb begin
    sum_x  = FW'(cal.max_x) + FW'(cal.min_x);
    sum_y  = FW'(cal.max_y) + FW'(cal.min_y);
    half_x = sum_x + FW'({1'b0, sum_x[FW-1]});
    half_y = sum_y + FW'({1'b0, sum_y[FW-1]});
    cen_x  = half_x >>> 1;
    cen_y  = half_y >>> 1;
    dx     = FW'(in_word.sample_x) - cen_x;
    dy     = FW'(in_word.sample_y) - cen_y;
    dxw    = DW'(dx);
    dyw    = DW'(dy);
    vec_next.zero = (dx == '0) && (dy == '0);
    if (dx[FW-1]) begin
      if (!dy[FW-1]) begin
        xw         = dyw;
        yw         = -dxw;
        vec_next.z = hdg_pkg::Z_QUARTER;
      end else begin
        xw         = -dyw;
        yw         = dxw;
        vec_next.z = -hdg_pkg::Z_QUARTER;
      end
    end else begin
      xw         = dxw;
      yw         = dyw;
      vec_next.z = '0;
    end
    vec_next.x = xw <<< hdg_pkg::PRESCALE_BITS;
    vec_next.y = yw <<< hdg_pkg::PRESCALE_BITS;
  end

  assign in_word.ready = !valid || ready_i;
  assign valid_o       = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_word.ready) begin
      valid <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      vec_o <= vec_next;
    end
  end

endmodule

### src/hdg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdg_cell
// One vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module hdg_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_i,
  output logic              ready_o,
  input  hdg_pkg::hdg_vec_t vec_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hdg_pkg::hdg_vec_t vec_o
);

  localparam logic signed [hdg_pkg::ZW-1:0] ATAN = hdg_pkg::atan_entry(STAGE);

  logic signed [hdg_pkg::DW-1:0] xs, ys;
  hdg_pkg::hdg_vec_t             vec_next;
  logic                          valid;

  always_comb begin
    xs            = vec_i.x >>> STAGE;
    ys            = vec_i.y >>> STAGE;
    vec_next.zero = vec_i.zero;
    if (!vec_i.y[hdg_pkg::DW-1]) begin
      vec_next.x = vec_i.x + ys;
      vec_next.y = vec_i.y - xs;
      vec_next.z = vec_i.z + ATAN;
    end else begin
      vec_next.x = vec_i.x - ys;
      vec_next.y = vec_i.y + xs;
      vec_next.z = vec_i.z - ATAN;
    end
  end

  assign ready_o = !valid || ready_i;
  assign valid_o = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_o) begin
      valid <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      vec_o <= vec_next;
    end
  end

endmodule

### src/hdg_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdg_post
// Rounds the angle to the output precision, clamps it to a half turn, gives
// zero for a zero vector and holds the result in the output register.
// ----------------------------------------------------------------------------
module hdg_post #(
  parameter int FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_i,
  output logic              ready_o,
  input  hdg_pkg::hdg_vec_t vec_i,
  hdg_out_if.source         out_word
);

  localparam int ZW    = hdg_pkg::ZW;
  localparam int SHIFT = hdg_pkg::ANGLE_FRAC - FRACTION_BITS;
  localparam logic signed [ZW-1:0] HALF = ZW'(2 ** (SHIFT - 1));
  localparam logic signed [ZW-1:0] LIM  = ZW'(hdg_pkg::HALF_TURN_DEG * (2 ** FRACTION_BITS));

  logic signed [ZW-1:0]                 rounded, t, clamped;
  logic signed [hdg_pkg::HEADING_W-1:0] heading_next;
  logic                                 valid;

  always_comb begin
    rounded = vec_i.z + HALF;
    t       = rounded >>> SHIFT;
    if (t > LIM) begin
      clamped = LIM;
    end else if (t < -LIM) begin
      clamped = -LIM;
    end else begin
      clamped = t;
    end
    heading_next = vec_i.zero ? '0 : clamped[hdg_pkg::HEADING_W-1:0];
  end

  assign ready_o        = !valid || out_word.ready;
  assign out_word.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_o) begin
      valid <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      out_word.heading_deg <= heading_next;
    end
  end

endmodule

### src/compass_heading_with_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_with_offset
// Hard-iron corrected compass heading from X/Y magnetometer samples.
//
// A word on sample_in carries one signed X/Y sample pair. The block subtracts
// the calibration center (max+min)/2 of each axis and returns atan2(dy, dx) in
// degrees on heading_out, signed with FRACTION_BITS fractional bits. A zero
// vector gives zero. The four calibration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while no
// word is in flight, as the block itself does not enforce it. The datapath
// is a prep stage, a chain of ROTATION_STEPS rotation cells and an output
// register. One word is accepted every cycle while the receiver keeps
// heading_out.ready high. Every stage has its own valid bit; when the
// receiver stalls, the output register holds its word and the earlier
// stages keep filling until the chain is full, then sample_in.ready drops.
// Reset empties all stages and clears the calibration registers to zero.
// ----------------------------------------------------------------------------
module compass_heading_with_offset #(
  parameter int ROTATION_STEPS = 16,
  parameter int FRACTION_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  hdg_in_if.sink                            sample_in,
  hdg_out_if.source                         heading_out,
  input  logic                              cfg_we,
  input  logic [hdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdg_pkg::SAMPLE_W-1:0]      cfg_data
);

  hdg_pkg::hdg_cal_t         cal;
  hdg_pkg::hdg_vec_t         vec [ROTATION_STEPS+1];
  wire  [ROTATION_STEPS:0]   stage_valid;
  wire  [ROTATION_STEPS:0]   stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (hdg_pkg::hdg_reg_t'(cfg_index))
        hdg_pkg::REG_MIN_X: cal.min_x <= cfg_data;
        hdg_pkg::REG_MAX_X: cal.max_x <= cfg_data;
        hdg_pkg::REG_MIN_Y: cal.min_y <= cfg_data;
        hdg_pkg::REG_MAX_Y: cal.max_y <= cfg_data;
      endcase
    end
  end

  hdg_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .cal     (cal),
    .in_word (sample_in),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .vec_o   (vec[0])
  );

  for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_cell
    hdg_cell #(
      .STAGE (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .vec_i   (vec[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .vec_o   (vec[k+1])
    );
  end

  hdg_post #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .valid_i  (stage_valid[ROTATION_STEPS]),
    .ready_o  (stage_ready[ROTATION_STEPS]),
    .vec_i    (vec[ROTATION_STEPS]),
    .out_word (heading_out)
  );

endmodule

### src/hdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdg_checker
// Port-level assertions for the compass heading block.
// ----------------------------------------------------------------------------
module hdg_checker #(
  parameter int FRACTION_BITS = 8
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [hdg_pkg::HEADING_W-1:0]  heading_deg
);

  localparam int LIM = hdg_pkg::HALF_TURN_DEG * (2 ** FRACTION_BITS);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("heading word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(heading_deg))
    else $error("heading word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (FRACTION_BITS > 8) ||
                  (($signed(heading_deg) <= LIM) && ($signed(heading_deg) >= -LIM)))
    else $error("heading outside a half turn");

endmodule

bind compass_heading_with_offset hdg_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_hdg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_in.valid),
  .in_ready    (sample_in.ready),
  .out_valid   (heading_out.valid),
  .out_ready   (heading_out.ready),
  .heading_deg (heading_out.heading_deg)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for compass_heading_with_offset.
//
// Sample words are driven on the input channel and every accepted word is
// run through a software CORDIC that predicts the heading under the current
// hard-iron calibration. Heading words are checked in order against those
// predictions. A short directed set covers the axes, the zero vector and the
// extreme offsets, then random words run under several calibrations while the
// sender and the receiver stall at different rates.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ROTATION_STEPS = 16;
  localparam int FRACTION_BITS  = 8;
  localparam int DRAIN_CYCLES   = ROTATION_STEPS + 6;
  localparam int SEGMENT_WORDS  = 67;
  localparam int unsigned LIMIT = 300000;

  localparam int SAMPLE_W      = hdg_pkg::SAMPLE_W;
  localparam int HEADING_W     = hdg_pkg::HEADING_W;
  localparam int CFG_IDX_W     = hdg_pkg::CFG_IDX_W;
  localparam int TABLE_LEN     = hdg_pkg::TABLE_LEN;
  localparam int ANGLE_FRAC    = hdg_pkg::ANGLE_FRAC;
  localparam int PRESCALE_BITS = hdg_pkg::PRESCALE_BITS;
  localparam int RIGHT_ANGLE   = hdg_pkg::RIGHT_ANGLE;
  localparam int HALF_TURN_DEG = hdg_pkg::HALF_TURN_DEG;

  localparam longint ATAN_DEG [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0]  sx;
    logic signed [SAMPLE_W-1:0]  sy;
    logic signed [HEADING_W-1:0] heading;
  } heading_due_t;

  class heading_scoreboard;
    logic signed [SAMPLE_W-1:0] cal [4];
    heading_due_t               due_q [$];
    int                         errors;

    function new();
      foreach (cal[i]) cal[i] = '0;
      errors = 0;
    endfunction

    function void set_cal(hdg_pkg::hdg_reg_t idx, logic signed [SAMPLE_W-1:0] value);
      cal[idx] = value;
    endfunction

    function int centre(hdg_pkg::hdg_reg_t lo_reg, hdg_pkg::hdg_reg_t hi_reg);
      return (int'(cal[hi_reg]) + int'(cal[lo_reg])) / 2;
    endfunction

    function logic signed [HEADING_W-1:0] predict_heading(
      logic signed [SAMPLE_W-1:0] sx, logic signed [SAMPLE_W-1:0] sy);
      longint dx, dy, x, y, z, xs, ys, t, lim;
      dx = longint'(sx) - centre(hdg_pkg::REG_MIN_X, hdg_pkg::REG_MAX_X);
      dy = longint'(sy) - centre(hdg_pkg::REG_MIN_Y, hdg_pkg::REG_MAX_Y);
      if (dx == 0 && dy == 0) begin
        return '0;
      end
      if (dx < 0) begin
        if (dy >= 0) begin
          x = dy;
          y = -dx;
          z = longint'(RIGHT_ANGLE) << ANGLE_FRAC;
        end else begin
          x = -dy;
          y = dx;
          z = -(longint'(RIGHT_ANGLE) << ANGLE_FRAC);
        end
      end else begin
        x = dx;
        y = dy;
        z = 0;
      end
      x = x <<< PRESCALE_BITS;
      y = y <<< PRESCALE_BITS;
      for (int i = 0; i < ROTATION_STEPS && i < TABLE_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_DEG[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_DEG[i];
        end
      end
      t = (z + (longint'(1) << (ANGLE_FRAC - FRACTION_BITS - 1)))
          >>> (ANGLE_FRAC - FRACTION_BITS);
      lim = longint'(HALF_TURN_DEG) << FRACTION_BITS;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t[HEADING_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] sx,
                              logic signed [SAMPLE_W-1:0] sy);
      heading_due_t entry;
      entry.sx = sx;
      entry.sy = sy;
      entry.heading = predict_heading(sx, sy);
      due_q.push_back(entry);
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    task report(string what);
      errors++;
      $display("ERROR: %s", what);
    endtask

    task check_heading(logic signed [HEADING_W-1:0] heading);
      heading_due_t entry;
      if (due_q.size() == 0) begin
        report($sformatf("heading word %0d arrived with no sample pending", heading));
      end else begin
        entry = due_q.pop_front();
        if (heading !== entry.heading) begin
          report($sformatf("heading %0d, expected %0d for sample (%0d, %0d)",
                           heading, entry.heading, entry.sx, entry.sy));
        end
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SAMPLE_W-1:0]    cfg_data;
  int unsigned            cycle_count;
  int                     src_idle_pct;
  int                     sink_idle_pct;
  heading_scoreboard      sb;

  hdg_in_if  sample_ch ();
  hdg_out_if heading_ch ();

  compass_heading_with_offset #(
    .ROTATION_STEPS(ROTATION_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_ch),
    .heading_out(heading_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      heading_ch.ready <= 1'b0;
    end else begin
      if (heading_ch.valid && heading_ch.ready) begin
        sb.check_heading(heading_ch.heading_deg);
      end
      heading_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sx,
                             input logic signed [SAMPLE_W-1:0] sy);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.sample_x <= sx;
    sample_ch.sample_y <= sy;
    do begin
      @(posedge clk);
    end while (!sample_ch.ready);
    sb.note_sample(sx, sy);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_cal(input int mnx, input int mxx, input int mny, input int mxy);
    hdg_pkg::hdg_reg_t   regs [4];
    logic [SAMPLE_W-1:0] vals [4];
    regs = '{hdg_pkg::REG_MIN_X, hdg_pkg::REG_MAX_X, hdg_pkg::REG_MIN_Y, hdg_pkg::REG_MAX_Y};
    vals = '{mnx[SAMPLE_W-1:0], mxx[SAMPLE_W-1:0], mny[SAMPLE_W-1:0], mxy[SAMPLE_W-1:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.set_cal(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_sample();
    int                         kind;
    int                         cx;
    int                         cy;
    int                         off;
    logic signed [SAMPLE_W-1:0] sx;
    logic signed [SAMPLE_W-1:0] sy;
    kind = $urandom_range(0, 9);
    cx = sb.centre(hdg_pkg::REG_MIN_X, hdg_pkg::REG_MAX_X);
    cy = sb.centre(hdg_pkg::REG_MIN_Y, hdg_pkg::REG_MAX_Y);
    case (kind)
      5, 6: begin
        sx = clamp_sample(cx + int'($urandom_range(0, 8)) - 4);
        sy = clamp_sample(cy + int'($urandom_range(0, 8)) - 4);
      end
      7: begin
        if ($urandom_range(0, 1) == 1) begin
          sx = clamp_sample(cx);
          sy = SAMPLE_W'($urandom);
        end else begin
          sx = SAMPLE_W'($urandom);
          sy = clamp_sample(cy);
        end
      end
      8: begin
        off = $urandom_range(1, 20000);
        sx = clamp_sample(($urandom_range(0, 1) == 1) ? cx + off : cx - off);
        sy = clamp_sample(($urandom_range(0, 1) == 1) ? cy + off : cy - off);
      end
      9: begin
        sx = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
        sy = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        sx = SAMPLE_W'($urandom);
        sy = SAMPLE_W'($urandom);
      end
    endcase
    send_sample(sx, sy);
  endtask

  initial begin
    int c;
    int r;
    int d;
    int e;
    sb = new();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= hdg_pkg::REG_MIN_X;
    cfg_data           <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.sample_x <= '0;
    sample_ch.sample_y <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Calibration at its reset value: axes, diagonals and the zero vector.
    send_sample(0, 0);
    send_sample(-1, 0);
    send_sample(-32768, 0);
    send_sample(32767, 0);
    send_sample(0, 32767);
    send_sample(0, -32768);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(1, -1);
    send_sample(-1, -1);
    send_sample(5, 3);
    drain();

    // Centers at the far ends give the widest offset-corrected vectors.
    program_cal(-32768, -32768, 32767, 32767);
    send_sample(32767, -32768);
    send_sample(32767, 32767);
    send_sample(-32768, 32767);
    send_sample(-32768, -32768);
    drain();

    program_cal(32767, 32767, -32768, -32768);
    send_sample(-32768, 32767);
    send_sample(-32768, -32768);
    send_sample(32767, -32768);
    drain();

    // Minimum above maximum on X, with odd negative sums that truncate toward zero.
    program_cal(5, -8, -7, 2);
    send_sample(-1, -2);
    send_sample(-2, -2);
    send_sample(-1, -3);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      src_idle_pct  = (seg < 2) ? 10 : ((seg < 4) ? 78 : 0);
      sink_idle_pct = (seg < 2) ? 78 : ((seg < 4) ? 10 : 0);
      case (seg % 4)
        0: begin
          c = int'($urandom_range(0, 16000)) - 8000;
          r = $urandom_range(100, 20000);
          d = int'($urandom_range(0, 16000)) - 8000;
          e = $urandom_range(100, 20000);
          program_cal(c - r, c + r, d - e, d + e);
        end
        1: program_cal(-32768, 32767, 32767, 32767);
        2: program_cal(int'($urandom_range(0, 65535)) - 32768,
                       int'($urandom_range(0, 65535)) - 32768,
                       int'($urandom_range(0, 65535)) - 32768,
                       int'($urandom_range(0, 65535)) - 32768);
        default: begin
          c = int'($urandom_range(0, 16000)) - 8000;
          r = $urandom_range(1, 20000);
          d = int'($urandom_range(0, 16000)) - 8000;
          e = $urandom_range(1, 20000);
          program_cal(c + r, c - r, d + e, d - e);
        end
      endcase
      repeat (SEGMENT_WORDS) send_random_sample();
      drain();
    end

    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
src/hdg_pkg.sv
src/hdg_if.sv
src/hdg_prep.sv
src/hdg_cell.sv
src/hdg_post.sv
src/compass_heading_with_offset.sv
src/hdg_checker.sv
test/testbench.sv
